@@ rtl/csktm_pkg.sv @@
// shared types and constants of the clock skew timestamp mapper
`default_nettype none
package csktm_pkg;

    // default parameter values
    localparam int RATE_FRAC_BITS_DEF   = 30;
    localparam int DEVICE_TIME_BITS_DEF = 32;

    // fixed field widths
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int DEN_W      = 84;

    // nanoseconds in one millisecond
    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    // register defaults
    localparam logic [31:0] WINDOW_RST = 32'd1000;
    localparam logic [16:0] WEIGHT_RST = 17'd6554;
    localparam logic [31:0] MINRATE_RST = 32'd966367642;
    localparam logic [31:0] MAXRATE_RST = 32'd1181116006;
    localparam logic [16:0] WEIGHT_ONE = 17'h10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MINRATE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAXRATE = 2'd3;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_REARM, OP_ANCHOR, OP_ACC, OP_DEN0, OP_DEN1,
        OP_DSAT, OP_DIV, OP_BL0, OP_BL1, OP_BLR, OP_CLAMP, OP_NEXT,
        OP_M0, OP_M1, OP_M2, OP_SUM, OP_CAP, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic is_reset_item;
        logic reanchor;
        logic cal_due;
        logic host_adv;
        logic div_sat;
        logic div_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/clock_skew_timestamp_mapper_top.sv @@
// top level of the clock skew compensated timestamp mapper
`default_nettype none
// Maps a wrapping device millisecond counter into host nanoseconds, with a
// drift rate recalibrated from elapsed host time. One item is worked at a
// time: a reset item, a re-anchoring sample, an ordinary sample, or a
// sample at a calibration point. At a calibration point where host time has
// advanced, the observed rate comes from the 32-step serial divider unless
// it saturates; the step scaling uses split multiplies. A finished result
// waits in the output register while the next item is taken; a result that
// is still stalled there when the next one is ready holds the block.
// Configuration is written through a plain write port; the user must write
// it only while the block is idle, which the block itself does not enforce.
module clock_skew_timestamp_mapper_top
    import csktm_pkg::*;
#(
    parameter int RATE_FRAC_BITS   = RATE_FRAC_BITS_DEF,
    parameter int DEVICE_TIME_BITS = DEVICE_TIME_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire                  i_kind,
    input  wire [31:0]           i_mcu_time_ms,
    input  wire [63:0]           i_reception_time_ns,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [63:0]          o_mapped_time_ns,
    output logic                 o_reanchored,
    output logic [31:0]          o_current_rate
);

    t_cmd    cmd;
    t_status status;
    logic    busy;

    // sequencer
    csktm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // datapath
    csktm_dp #(
        .RATE_FRAC_BITS   (RATE_FRAC_BITS),
        .DEVICE_TIME_BITS (DEVICE_TIME_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_kind              (i_kind),
        .i_mcu_time_ms       (i_mcu_time_ms),
        .i_reception_time_ns (i_reception_time_ns),
        .i_out_stall         (i_stall),
        .o_out_valid         (o_valid),
        .o_mapped_time_ns    (o_mapped_time_ns),
        .o_reanchored        (o_reanchored),
        .o_current_rate      (o_current_rate)
    );

    assign o_stall = busy;

    // an accepted item keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting an item");

    // a stalled result stays valid and unchanged
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mapped_time_ns)
                                  && $stable(o_reanchored) && $stable(o_current_rate)))
        else $error("stalled result changed");

    // a new result only appears while an item was being worked
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without an item in work");

endmodule
`default_nettype wire

@@ rtl/csktm_ctrl.sv @@
// sequencing state machine of the timestamp mapper
`default_nettype none
module csktm_ctrl
    import csktm_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [20:0] {
        S_IDLE   = 21'h000001,
        S_CHECK  = 21'h000002,
        S_REARM  = 21'h000004,
        S_ANCHOR = 21'h000008,
        S_ACC    = 21'h000010,
        S_CMP    = 21'h000020,
        S_DEN0   = 21'h000040,
        S_DEN1   = 21'h000080,
        S_DSAT   = 21'h000100,
        S_DIV    = 21'h000200,
        S_BL0    = 21'h000400,
        S_BL1    = 21'h000800,
        S_BLR    = 21'h001000,
        S_CLAMP  = 21'h002000,
        S_NEXT   = 21'h004000,
        S_M0     = 21'h008000,
        S_M1     = 21'h010000,
        S_M2     = 21'h020000,
        S_SUM    = 21'h040000,
        S_CAP    = 21'h080000,
        S_EMIT   = 21'h100000
    } t_state;

    t_state r_state, n_state;

    // next state and command
    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_status.is_reset_item) n_state = S_REARM;
                else if (i_status.reanchor)          n_state = S_ANCHOR;
                else                                 n_state = S_ACC;
            end
            S_REARM: begin
                o_cmd.op = OP_REARM;
                n_state  = S_IDLE;
            end
            S_ANCHOR: begin
                o_cmd.op = OP_ANCHOR;
                n_state  = S_EMIT;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = S_CMP;
            end
            S_CMP: begin
                priority if (i_status.cal_due && i_status.host_adv) n_state = S_DEN0;
                else if (i_status.cal_due)                          n_state = S_NEXT;
                else                                                n_state = S_M0;
            end
            S_DEN0: begin
                o_cmd.op = OP_DEN0;
                n_state  = S_DEN1;
            end
            S_DEN1: begin
                o_cmd.op = OP_DEN1;
                n_state  = S_DSAT;
            end
            S_DSAT: begin
                o_cmd.op = OP_DSAT;
                n_state  = i_status.div_sat ? S_BL0 : S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_status.div_last) n_state = S_BL0;
            end
            S_BL0: begin
                o_cmd.op = OP_BL0;
                n_state  = S_BL1;
            end
            S_BL1: begin
                o_cmd.op = OP_BL1;
                n_state  = S_BLR;
            end
            S_BLR: begin
                o_cmd.op = OP_BLR;
                n_state  = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.op = OP_CLAMP;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.op = OP_NEXT;
                n_state  = S_M0;
            end
            S_M0: begin
                o_cmd.op = OP_M0;
                n_state  = S_M1;
            end
            S_M1: begin
                o_cmd.op = OP_M1;
                n_state  = S_M2;
            end
            S_M2: begin
                o_cmd.op = OP_M2;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = S_CAP;
            end
            S_CAP: begin
                o_cmd.op = OP_CAP;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

@@ rtl/csktm_dp.sv @@
// mapper state, arithmetic units and output register
`default_nettype none
module csktm_dp
    import csktm_pkg::*;
#(
    parameter int RATE_FRAC_BITS   = RATE_FRAC_BITS_DEF,
    parameter int DEVICE_TIME_BITS = DEVICE_TIME_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    input  wire                  i_kind,
    input  wire [31:0]           i_mcu_time_ms,
    input  wire [63:0]           i_reception_time_ns,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output logic [63:0]          o_mapped_time_ns,
    output logic                 o_reanchored,
    output logic [31:0]          o_current_rate
);

    localparam int D = DEVICE_TIME_BITS;
    localparam int F = RATE_FRAC_BITS;
    localparam logic [31:0] RATE_ONE = 32'(64'd1 << F);

    // configuration
    logic [31:0] r_window, r_minr, r_maxr;
    logic [16:0] r_weight;
    // mapper state
    logic         r_anch;
    logic [D-1:0] r_prev_t;
    logic [63:0]  r_prev_mapped, r_anchor, r_acc, r_next;
    logic [31:0]  r_rate;
    // item and working registers
    logic         r_kind;
    logic [D-1:0] r_t, r_e;
    logic [63:0]  r_rx, r_hd, r_sum, r_res;
    logic         r_reanch;
    logic [DEN_W-1:0] r_den, r_rem;
    logic [31:0]  r_nlo, r_q;
    logic [4:0]   r_cnt;
    logic [48:0]  r_bl;
    logic [32:0]  r_blr;
    logic [51:0]  r_em;
    logic [83:0]  r_p;
    // output register
    logic         r_ovalid, r_oreanch;
    logic [63:0]  r_omap;
    logic [31:0]  r_orate;

    // combinational helpers
    logic [D-1:0]   e;
    logic [64:0]    acc_s, next_s;
    logic [51:0]    d_lo, d_hi, em_n;
    logic [63:0]    hs;
    logic [DEN_W:0] rem2;
    logic           ge;
    logic [16:0]    w, w_old;
    logic [48:0]    bl_a, bl_b;
    logic [57:0]    pm_lo, pm_hi;
    logic [63:0]    delta, sum;

    assign e      = r_t - r_prev_t;
    assign acc_s  = {1'b0, r_acc} + 65'(e);
    assign next_s = {1'b0, r_acc} + 65'(r_window);
    assign d_lo   = r_acc[31:0] * NS_PER_MS;
    assign d_hi   = r_acc[63:32] * NS_PER_MS;
    assign em_n   = r_e * NS_PER_MS;
    assign hs     = r_hd >> (32 - F);
    assign rem2   = {r_rem, r_nlo[31]};
    assign ge     = (rem2 >= {1'b0, r_den});
    assign w      = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;
    assign w_old  = WEIGHT_ONE - w;
    assign bl_a   = w_old * r_rate;
    assign bl_b   = w * r_q;
    assign pm_lo  = r_em[25:0] * r_rate;
    assign pm_hi  = r_em[51:26] * r_rate;
    assign delta  = 64'(r_p >> F);
    assign sum    = r_prev_mapped + delta;

    // status toward the controller
    always_comb begin
        o_status.is_reset_item = r_kind;
        o_status.reanchor      = !r_anch || (e == '0) || e[D-1];
        o_status.cal_due       = (r_acc >= r_next);
        o_status.host_adv      = ($signed(r_anchor) < $signed(r_rx));
        o_status.div_sat       = ({20'b0, hs} >= r_den);
        o_status.div_last      = (r_cnt == 5'd31);
        o_status.out_free      = !r_ovalid || !i_out_stall;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_weight <= WEIGHT_RST;
            r_minr   <= MINRATE_RST;
            r_maxr   <= MAXRATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW:  r_window <= i_cfg_data;
                REG_WEIGHT:  r_weight <= i_cfg_data[16:0];
                REG_MINRATE: r_minr   <= i_cfg_data;
                REG_MAXRATE: r_maxr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // mapper state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anch        <= 1'b0;
            r_prev_t      <= '0;
            r_prev_mapped <= '0;
            r_anchor      <= '0;
            r_acc         <= '0;
            r_next        <= 64'(WINDOW_RST);
            r_rate        <= RATE_ONE;
        end else begin
            unique case (i_cmd.op)
                OP_REARM: begin
                    r_anch <= 1'b0;
                    r_acc  <= '0;
                    r_next <= 64'(r_window);
                    r_rate <= RATE_ONE;
                end
                OP_ANCHOR: begin
                    r_anch        <= 1'b1;
                    r_prev_t      <= r_t;
                    r_prev_mapped <= r_rx;
                    r_anchor      <= r_rx;
                    r_acc         <= '0;
                    r_next        <= 64'(r_window);
                end
                OP_ACC: r_acc <= acc_s[64] ? '1 : acc_s[63:0];
                OP_CLAMP: begin
                    priority if (r_blr < {1'b0, r_minr}) r_rate <= r_minr;
                    else if (r_blr > {1'b0, r_maxr})     r_rate <= r_maxr;
                    else                                 r_rate <= r_blr[31:0];
                end
                OP_NEXT: r_next <= next_s[64] ? '1 : next_s[63:0];
                OP_CAP: begin
                    r_prev_t      <= r_t;
                    r_prev_mapped <= ($signed(r_rx) < $signed(r_sum)) ? r_rx : r_sum;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_kind <= i_kind;
                r_t    <= i_mcu_time_ms[D-1:0];
                r_rx   <= i_reception_time_ns;
            end
            OP_ANCHOR: begin
                r_res    <= r_rx;
                r_reanch <= 1'b1;
            end
            OP_ACC: r_e <= e;
            OP_DEN0: begin
                r_den <= {32'b0, d_lo};
                r_hd  <= r_rx - r_anchor;
            end
            OP_DEN1: r_den <= r_den + {d_hi, 32'b0};
            OP_DSAT: begin
                r_rem <= DEN_W'(hs);
                r_nlo <= 32'(r_hd << F);
                r_cnt <= '0;
                r_q   <= o_status.div_sat ? '1 : '0;
            end
            OP_DIV: begin
                r_rem <= ge ? DEN_W'(rem2 - {1'b0, r_den}) : rem2[DEN_W-1:0];
                r_q   <= {r_q[30:0], ge};
                r_nlo <= {r_nlo[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            OP_BL0: r_bl  <= bl_a;
            OP_BL1: r_bl  <= r_bl + bl_b;
            OP_BLR: r_blr <= 33'((r_bl + 49'd32768) >> 16);
            OP_M0:  r_em  <= em_n;
            OP_M1:  r_p   <= {26'b0, pm_lo};
            OP_M2:  r_p   <= r_p + {pm_hi, 26'b0};
            OP_SUM: r_sum <= (!r_prev_mapped[63] && sum[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : sum;
            OP_CAP: begin
                r_res    <= ($signed(r_rx) < $signed(r_sum)) ? r_rx : r_sum;
                r_reanch <= 1'b0;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_omap    <= r_res;
            r_oreanch <= r_reanch;
            r_orate   <= r_rate;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_mapped_time_ns = r_omap;
    assign o_reanchored     = r_oreanch;
    assign o_current_rate   = r_orate;

endmodule
`default_nettype wire

@@ bench/clock_skew_timestamp_mapper_top_test.sv @@
// testbench of the clock skew timestamp mapper: directed and random traffic checked against a predictor
`default_nettype none
module clock_skew_timestamp_mapper_top_test
    import csktm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic [63:0] mapped;
        logic        reanch;
        logic [31:0] rate;
    } t_mapping;

    // scoreboard: mapping predictor and queue of expected mappings
    class mapping_board;
        logic [31:0] window = WINDOW_RST;
        logic [16:0] weight = WEIGHT_RST;
        logic [31:0] rate_lo = MINRATE_RST;
        logic [31:0] rate_hi = MAXRATE_RST;
        bit          anchored;
        logic [31:0] last_dev;
        logic [63:0] last_mapped;
        logic [63:0] anchor_ns;
        logic [63:0] acc_ms;
        logic [63:0] next_cal;
        logic [31:0] rate;
        t_mapping    expected_q[$];
        int          errors;
        int          results;
        int          reanchors;
        int          recals;

        function new();
            rearm();
        endfunction

        function void rearm();
            anchored = 0;
            acc_ms   = 0;
            next_cal = {32'd0, window};
            rate     = 32'd1 << 30;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_WINDOW:  window  = val;
                REG_WEIGHT:  weight  = val[16:0];
                REG_MINRATE: rate_lo = val;
                default:     rate_hi = val;
            endcase
        endfunction

        function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[64] ? '1 : s[63:0];
        endfunction

        // host ns over device ms scaled to ns, Q2.30, saturated
        function logic [31:0] measured_rate(logic [63:0] host_ns, logic [63:0] dev_ms);
            logic [127:0] num;
            logic [127:0] den;
            logic [127:0] q;
            num = {64'd0, host_ns} << 30;
            den = {64'd0, dev_ms} * 128'd1000000;
            q   = num / den;
            return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
        endfunction

        function void note_item(bit kind, logic [31:0] t, logic [63:0] rx);
            logic [31:0]  step;
            logic [63:0]  w;
            logic [63:0]  blended;
            logic [127:0] prod;
            logic [63:0]  sum;
            t_mapping     m;
            if (kind) begin
                rearm();
                return;
            end
            step = t - last_dev;
            if (anchored && (step == 0 || step[31]))
                anchored = 0;
            if (!anchored) begin
                anchored    = 1;
                last_dev    = t;
                last_mapped = rx;
                anchor_ns   = rx;
                acc_ms      = 0;
                next_cal    = {32'd0, window};
                m = '{rx, 1'b1, rate};
                reanchors++;
            end else begin
                acc_ms = sat_sum(acc_ms, {32'd0, step});
                // calibration point: if host time advanced, blend measured rate, then clamp
                if (acc_ms >= next_cal) begin
                    if ($signed(anchor_ns) < $signed(rx)) begin
                        w = (weight > 17'h10000) ? 64'h10000 : {47'd0, weight};
                        blended = ((64'h10000 - w) * rate
                                + w * measured_rate(rx - anchor_ns, acc_ms) + 64'h8000) >> 16;
                        if (blended < rate_lo)
                            blended = rate_lo;
                        else if (blended > rate_hi)
                            blended = rate_hi;
                        rate = blended[31:0];
                        recals++;
                    end
                    next_cal = sat_sum(acc_ms, {32'd0, window});
                end
                prod = ({96'd0, step} * 128'd1000000) * {96'd0, rate};
                sum  = last_mapped + prod[93:30];
                if (!last_mapped[63] && sum[63])
                    sum = S64_MAX;
                m.mapped    = ($signed(rx) < $signed(sum)) ? rx : sum;
                m.reanch    = 0;
                m.rate      = rate;
                last_dev    = t;
                last_mapped = m.mapped;
            end
            expected_q.push_back(m);
        endfunction

        function void check_result(logic [63:0] mapped, logic reanch, logic [31:0] r);
            t_mapping m;
            results++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: mapped %h reanchored %b rate %h",
                             mapped, reanch, r);
                return;
            end
            m = expected_q.pop_front();
            if (mapped !== m.mapped || reanch !== m.reanch || r !== m.rate) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch #%0d: mapped %h/%h reanchored %b/%b rate %h/%h",
                             results, m.mapped, mapped, m.reanch, reanch, m.rate, r);
            end
        endfunction
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = REG_WINDOW;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 0;
    logic                  o_stall;
    logic                  i_kind = 0;
    logic [31:0]           i_mcu_time_ms = '0;
    logic [63:0]           i_reception_time_ns = '0;
    logic                  o_valid;
    logic                  i_stall = 0;
    logic [63:0]           o_mapped_time_ns;
    logic                  o_reanchored;
    logic [31:0]           o_current_rate;

    mapping_board board = new();
    bit           calm;
    int           stall_left;
    int           idle_cycles;
    int           samples;
    int           reset_items;
    int           settings;
    logic [31:0]  dev_ms;
    logic [63:0]  host_ns;

    clock_skew_timestamp_mapper_top u_top (.*);

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stall and checking of each result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_result(o_mapped_time_ns, o_reanchored, o_current_rate);
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1;
        end else begin
            i_stall <= 0;
            if ($urandom_range(0, 3) == 0)
                stall_left = idle_len();
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results still expected",
                     board.expected_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one input transfer; valid stays high when the next item follows at once
    task automatic send_item(bit kind, logic [31:0] t, logic [63:0] rx);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid             <= 1;
        i_kind              <= kind;
        i_mcu_time_ms       <= t;
        i_reception_time_ns <= rx;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        board.note_item(kind, t, rx);
        if (kind)
            reset_items++;
        else
            samples++;
    endtask

    // wait for the block to go idle, then write all four registers
    task automatic configure(logic [31:0] win, logic [31:0] wgt,
                             logic [31:0] lo, logic [31:0] hi);
        i_valid <= 0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1;
            i_cfg_index <= k[CFG_IDX_W-1:0];
            i_cfg_data  <= (k == 0) ? win : (k == 1) ? wgt : (k == 2) ? lo : hi;
            @(posedge i_clk);
            board.write_reg(k[CFG_IDX_W-1:0], (k == 0) ? win : (k == 1) ? wgt :
                                              (k == 2) ? lo : hi);
        end
        i_cfg_we <= 0;
        settings++;
    endtask

    // mostly steady device and host clocks with some drift, plus noise
    task automatic random_traffic(int count);
        int          r;
        logic [31:0] step;
        logic [63:0] ns_per_ms;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_item(1'b1, $urandom(), {$urandom(), $urandom()});
            end else if (r < 7) begin
                dev_ms  = $urandom();
                host_ns = {$urandom(), $urandom()};
                send_item(1'b0, dev_ms, host_ns);
            end else if (r < 10) begin
                // zero step or backward step past half range
                if (r < 8)
                    dev_ms = dev_ms + 32'h8000_0000 + $urandom_range(0, 1000);
                send_item(1'b0, dev_ms, host_ns + 64'd1000);
            end else begin
                step = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3000)
                                                    : $urandom_range(1, 60);
                ns_per_ms = $urandom_range(900000, 1100000);
                dev_ms  = dev_ms + step;
                if ($urandom_range(0, 49) == 0)
                    host_ns = host_ns - {32'd0, $urandom_range(0, 1000000)};
                else
                    host_ns = host_ns + step * ns_per_ms
                            + {32'd0, $urandom_range(0, 1000)};
                send_item(1'b0, dev_ms, host_ns);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        configure(WINDOW_RST, {15'd0, WEIGHT_RST}, MINRATE_RST, MAXRATE_RST);
        calm = 1;

        // directed: anchoring, zero and half-range steps, wrap, calibration
        send_item(1'b1, '0, '0);
        send_item(1'b0, 32'd0, 64'd0);
        send_item(1'b0, 32'd1, 64'd1000000);
        send_item(1'b0, 32'd1, 64'd2000000);
        send_item(1'b0, 32'h8000_0001, 64'd3000000);
        send_item(1'b0, 32'hFFFF_FFFF, 64'd2200000000000);
        send_item(1'b0, 32'd5, 64'd2200006000000);
        send_item(1'b1, '1, '1);
        send_item(1'b0, 32'd100, S64_MIN);
        send_item(1'b0, 32'd1100, S64_MIN + 64'd1050000000);
        send_item(1'b0, 32'd2200, S64_MIN + 64'd2000000000);
        // host time stepping backward at a calibration point
        send_item(1'b0, 32'd3300, S64_MIN + 64'd5);
        send_item(1'b0, 32'd3310, S64_MIN + 64'd2100000000);
        // mapped time overflow near the top of the signed range
        send_item(1'b0, 32'd9000, S64_MAX - 64'd5);
        send_item(1'b0, 32'd9001, S64_MAX);
        send_item(1'b0, 32'd9002, S64_MAX);
        send_item(1'b0, '1, '1);
        send_item(1'b0, 32'h7FFF_FFFE, 64'h5555_5555_5555_5555);
        send_item(1'b0, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

        dev_ms  = $urandom();
        host_ns = {$urandom_range(0, 32'h3FFF_FFFF), $urandom()};
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: configure(WINDOW_RST, {15'd0, WEIGHT_RST}, MINRATE_RST, MAXRATE_RST);
                1: configure(32'd1, 32'h10000, 32'd0, 32'hFFFF_FFFF);
                2: configure(32'd0, 32'h1FFFF, 32'h5000_0000, 32'h3000_0000);
                3: configure(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
                4: configure(32'd50, 32'h8000, 32'h3C00_0000, 32'h4400_0000);
                default: configure(32'd200, 32'd1, 32'h3800_0000, 32'h4800_0000);
            endcase
            send_item(1'b1, $urandom(), {$urandom(), $urandom()});
            calm = ($urandom_range(0, 2) == 0);
            random_traffic(p == 0 ? 300 : 320);
            calm = 0;
        end

        i_valid <= 0;
        @(posedge i_clk);
        while (board.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("covered %0d samples, %0d reset items, %0d register settings",
                 samples, reset_items, settings);
        $display("checked %0d results: %0d re-anchors, %0d recalibrations",
                 board.results, board.reanchors, board.recals);
        if (board.errors == 0 && board.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results missing", board.errors,
                     board.expected_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
